// ===== design/polygon_convexity_check_macros.svh =====
// Assertion macros shared by the convexity checker.
`ifndef POLYGON_CONVEXITY_CHECK_MACROS_SVH
`define POLYGON_CONVEXITY_CHECK_MACROS_SVH

// clocked check, masked while reset is high
`define PCC_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// clocked check that also holds across reset
`define PCC_ASSERT_RST(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);

`endif

// ===== design/pcc_pkg.sv =====
// Shared types, widths and helpers for the polygon convexity checker.
package pcc_pkg;

   localparam int VERTEX_BITS = 16;
   localparam int COORD_BITS  = 16;
   localparam int DIFF_BITS   = COORD_BITS + 1;
   localparam int PROD_BITS   = 2 * DIFF_BITS;
   localparam int CROSS_BITS  = PROD_BITS + 1;
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);
   localparam int REQ_BYTES   = (2 * VERTEX_BITS + 7) / 8;
   localparam int RSP_BYTES   = 1;

   typedef logic signed [COORD_BITS-1:0] coord_type;
   typedef logic signed [DIFF_BITS-1:0]  diff_type;
   typedef logic signed [PROD_BITS-1:0]  prod_type;
   typedef logic signed [CROSS_BITS-1:0] cross_type;

   typedef struct packed {
      coord_type x;
      coord_type y;
   } vertex_type;

   // one unit of work for the back end: a turn, a polygon end, or both
   typedef struct packed {
      diff_type ux;
      diff_type uy;
      diff_type wx;
      diff_type wy;
      logic     has_turn;
      logic     is_end;
      logic     too_few;
   } job_type;

   typedef struct packed {
      logic full;
      logic valid;
   } queue_status_type;

   typedef enum logic [1:0] {
      SIGN_NONE = 2'd0,
      SIGN_POS  = 2'd1,
      SIGN_NEG  = 2'd2
   } sign_type;

   function automatic job_type make_turn(vertex_type a, vertex_type b, vertex_type c,
                                         logic last);
      job_type j;
      j.ux       = DIFF_BITS'(b.x) - DIFF_BITS'(a.x);
      j.uy       = DIFF_BITS'(b.y) - DIFF_BITS'(a.y);
      j.wx       = DIFF_BITS'(c.x) - DIFF_BITS'(b.x);
      j.wy       = DIFF_BITS'(c.y) - DIFF_BITS'(b.y);
      j.has_turn = 1'b1;
      j.is_end   = last;
      j.too_few  = 1'b0;
      return j;
   endfunction

endpackage

// ===== design/polygon_convexity_check.sv =====
// Polygon convexity check: vertices stream in one per request, the last one marked by
// req_tlast, and one response per polygon reports convex (all nonzero turn signs agree)
// or too_few (fewer than three vertices). A vertex is taken every cycle while the job queue
// has room; after the last vertex of a polygon with three or more vertices the input is held
// while the front end issues the two wrap-around turns. The cross product is a two-stage
// back end behind a four-entry job queue: a job is popped into the product registers, and
// the end job then sets the result register that drives rsp_tvalid.
module polygon_convexity_check
   import pcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [8*REQ_BYTES-1:0] req_tdata,  // vertex_x, vertex_y
   input  logic                   req_tlast,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [8*RSP_BYTES-1:0] rsp_tdata   // convex, too_few, zero pad
);

   logic             push, pop;
   job_type          push_job, head_job;
   queue_status_type status;

   pcc_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .q_full     (status.full),
      .push       (push),
      .push_job   (push_job)
   );

   pcc_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_job (push_job),
      .pop      (pop),
      .head_job (head_job),
      .status   (status)
   );

   pcc_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_job   (head_job),
      .status     (status),
      .pop        (pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

// ===== design/pcc_front.sv =====
// Front end: takes vertices, tracks first and recent vertices, issues turn jobs.
module pcc_front
   import pcc_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_tvalid,
   output logic                     req_tready,
   input  logic [8*REQ_BYTES-1:0]   req_tdata,
   input  logic                     req_tlast,
   input  logic                     q_full,
   output logic                     push,
   output job_type                  push_job
);

   typedef enum logic [2:0] {
      ST_RUN   = 3'b001,
      ST_WRAP1 = 3'b010,
      ST_WRAP2 = 3'b100
   } state_type;

   state_type  state_ff, state_in;
   vertex_type f0_ff, f0_in, f1_ff, f1_in, r0_ff, r0_in, r1_ff, r1_in;
   logic [1:0] cnt_ff, cnt_in;
   vertex_type v;
   logic       fire;

   assign v.x = coord_type'(req_tdata[VERTEX_BITS-1:0]);
   assign v.y = coord_type'(req_tdata[VERTEX_BITS +: VERTEX_BITS]);

   assign req_tready = (state_ff == ST_RUN) && !q_full;
   assign fire       = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      f0_in    = f0_ff;
      f1_in    = f1_ff;
      r0_in    = r0_ff;
      r1_in    = r1_ff;
      cnt_in   = cnt_ff;
      push     = 1'b0;
      push_job = make_turn(r0_ff, r1_ff, v, 1'b0);
      unique case (state_ff)
         ST_RUN: begin
            if (fire) begin
               if (cnt_ff == 2'd0) f0_in = v;
               if (cnt_ff == 2'd1) f1_in = v;
               r0_in = r1_ff;
               r1_in = v;
               if (cnt_ff != 2'd3) cnt_in = cnt_ff + 2'd1;
               if (cnt_ff >= 2'd2) begin
                  push = 1'b1;
                  if (req_tlast) state_in = ST_WRAP1;
               end else if (req_tlast) begin
                  push              = 1'b1;
                  push_job.has_turn = 1'b0;
                  push_job.is_end   = 1'b1;
                  push_job.too_few  = 1'b1;
                  cnt_in            = 2'd0;
               end
            end
         end
         ST_WRAP1: begin
            push_job = make_turn(r0_ff, r1_ff, f0_ff, 1'b0);
            if (!q_full) begin
               push     = 1'b1;
               state_in = ST_WRAP2;
            end
         end
         ST_WRAP2: begin
            push_job = make_turn(r1_ff, f0_ff, f1_ff, 1'b1);
            if (!q_full) begin
               push     = 1'b1;
               cnt_in   = 2'd0;
               state_in = ST_RUN;
            end
         end
         default: state_in = ST_RUN;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RUN;
         cnt_ff   <= 2'd0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
      end
      f0_ff <= f0_in;
      f1_ff <= f1_in;
      r0_ff <= r0_in;
      r1_ff <= r1_in;
   end

endmodule

// ===== design/pcc_queue.sv =====
// Short job queue between the front and back ends.
module pcc_queue
   import pcc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  job_type          push_job,
   input  logic             pop,
   output job_type          head_job,
   output queue_status_type status
);

   job_type              entry_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QCNT_BITS-1:0] cnt_ff, cnt_in;
   logic                 do_push, do_pop;

   assign status.full  = (cnt_ff == QCNT_BITS'(QUEUE_DEPTH));
   assign status.valid = (cnt_ff != '0);
   assign do_push      = push && !status.full;
   assign do_pop       = pop && status.valid;
   assign head_job     = entry_ff[rd_ff];

   always_comb begin
      wr_in  = do_push ? wr_ff + QPTR_BITS'(1) : wr_ff;
      rd_in  = do_pop  ? rd_ff + QPTR_BITS'(1) : rd_ff;
      cnt_in = cnt_ff + QCNT_BITS'(do_push) - QCNT_BITS'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) entry_ff[wr_ff] <= push_job;
   end

endmodule

// ===== design/pcc_back.sv =====
// Back end: cross products, sign tracking and the result register.
module pcc_back
   import pcc_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  job_type                head_job,
   input  queue_status_type       status,
   output logic                   pop,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [8*RSP_BYTES-1:0] rsp_tdata
);

   logic     s1_valid_ff, s1_valid_in;
   logic     s1_turn_ff, s1_end_ff, s1_few_ff;
   prod_type p1_ff, p2_ff;
   sign_type seen_ff, seen_in, s;
   logic     conflict_ff, conflict_in, conflict_now;
   logic     out_valid_ff, out_valid_in, out_convex_ff, out_few_ff;
   cross_type z;
   logic     stall, process;

   assign stall   = s1_valid_ff && s1_end_ff && out_valid_ff && !rsp_tready;
   assign pop     = status.valid && !stall;
   assign process = s1_valid_ff && !stall;

   assign z = CROSS_BITS'(p1_ff) - CROSS_BITS'(p2_ff);

   always_comb begin
      priority if (!s1_turn_ff || z == '0) s = SIGN_NONE;
      else if (z[CROSS_BITS-1])            s = SIGN_NEG;
      else                                 s = SIGN_POS;
   end

   always_comb begin
      conflict_now = conflict_ff ||
                     (s != SIGN_NONE && seen_ff != SIGN_NONE && seen_ff != s);
      seen_in      = seen_ff;
      conflict_in  = conflict_ff;
      s1_valid_in  = stall ? s1_valid_ff : status.valid;
      out_valid_in = out_valid_ff && !rsp_tready;
      if (process) begin
         if (s1_end_ff) begin
            seen_in      = SIGN_NONE;
            conflict_in  = 1'b0;
            out_valid_in = 1'b1;
         end else begin
            if (seen_ff == SIGN_NONE) seen_in = s;
            conflict_in = conflict_now;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         seen_ff      <= SIGN_NONE;
         conflict_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         seen_ff      <= seen_in;
         conflict_ff  <= conflict_in;
         out_valid_ff <= out_valid_in;
      end
      if (pop) begin
         p1_ff      <= head_job.ux * head_job.wy;
         p2_ff      <= head_job.uy * head_job.wx;
         s1_turn_ff <= head_job.has_turn;
         s1_end_ff  <= head_job.is_end;
         s1_few_ff  <= head_job.too_few;
      end
      if (process && s1_end_ff) begin
         out_convex_ff <= !s1_few_ff && !conflict_now;
         out_few_ff    <= s1_few_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {(8*RSP_BYTES-2)'(0), out_few_ff, out_convex_ff};

endmodule

// ===== design/pcc_checker.sv =====
// Port-level checks for the polygon convexity checker, bound to the top level.
`include "polygon_convexity_check_macros.svh"

module pcc_checker
   import pcc_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   req_tlast,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [8*RSP_BYTES-1:0] rsp_tdata
);

   // polygons closed on the input but not yet answered
   logic [3:0] pending_ff, pending_in;
   logic       end_in, end_out, rsp_stalled;

   assign end_in      = req_tvalid && req_tready && req_tlast;
   assign end_out     = rsp_tvalid && rsp_tready;
   assign rsp_stalled = rsp_tvalid && !rsp_tready;
   assign pending_in  = pending_ff + 4'(end_in) - 4'(end_out);

   always_ff @(posedge clock) begin
      if (reset) pending_ff <= '0;
      else       pending_ff <= pending_in;
   end

   `PCC_ASSERT_RST(a_idle_after_reset, reset |=> !rsp_tvalid, "response valid after reset")
   `PCC_ASSERT(a_flags_exclusive, rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1]), "both flags set")
   `PCC_ASSERT(a_no_orphan, rsp_tvalid |-> pending_ff != 4'd0, "response without a closed polygon")
   `PCC_ASSERT(a_rsp_hold, rsp_stalled |=> rsp_tvalid && $stable(rsp_tdata), "response changed")

endmodule

bind polygon_convexity_check pcc_checker u_checker (.*);

// ===== tb/polygon_convexity_check_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for polygon_convexity_check: vertex streams against a turn-sign predictor.
module polygon_convexity_check_tb;
   import pcc_pkg::*;

   typedef struct packed {
      logic convex;
      logic too_few;
   } verdict_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [8*REQ_BYTES-1:0] req_tdata = '0;
   logic                   req_tlast = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [8*RSP_BYTES-1:0] rsp_tdata;

   int unsigned req_gap_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int          hold_cycles = 0;
   int          mismatches = 0;
   int          items_sent = 0;

   verdict_type outcome_q[$];
   int          shape_x[$];
   int          shape_y[$];

   // predictor state for the polygon in flight
   longint   head_x[2], head_y[2], tail_x[2], tail_y[2];
   int       vertices_seen = 0;
   sign_type turn_sign = SIGN_NONE;
   bit       turns_disagree = 1'b0;

   polygon_convexity_check u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("[polygon_convexity_check] ERROR");
      $finish;
   end

   function automatic void clear_polygon();
      for (int i = 0; i < 2; i++) begin
         head_x[i] = 0;
         head_y[i] = 0;
         tail_x[i] = 0;
         tail_y[i] = 0;
      end
      vertices_seen  = 0;
      turn_sign      = SIGN_NONE;
      turns_disagree = 1'b0;
   endfunction

   function automatic longint widen_coord(logic [VERTEX_BITS-1:0] raw);
      coord_type c;
      c = raw[COORD_BITS-1:0];
      return longint'(c);
   endfunction

   function automatic void fold_turn(longint ax, longint ay, longint bx, longint by,
                                     longint cx, longint cy);
      longint   z;
      sign_type s;
      z = (bx - ax) * (cy - by) - (by - ay) * (cx - bx);
      s = (z > 0) ? SIGN_POS : ((z < 0) ? SIGN_NEG : SIGN_NONE);
      if (s != SIGN_NONE) begin
         if (turn_sign == SIGN_NONE) turn_sign = s;
         else if (turn_sign != s) turns_disagree = 1'b1;
      end
   endfunction

   function automatic void fold_vertex(logic [VERTEX_BITS-1:0] rx, logic [VERTEX_BITS-1:0] ry,
                                       logic last);
      longint      vx, vy;
      verdict_type v;
      vx = widen_coord(rx);
      vy = widen_coord(ry);
      if (vertices_seen == 0) begin
         head_x[0] = vx;
         head_y[0] = vy;
      end else if (vertices_seen == 1) begin
         head_x[1] = vx;
         head_y[1] = vy;
      end else begin
         fold_turn(tail_x[0], tail_y[0], tail_x[1], tail_y[1], vx, vy);
      end
      tail_x[0] = tail_x[1];
      tail_y[0] = tail_y[1];
      tail_x[1] = vx;
      tail_y[1] = vy;
      if (vertices_seen < 3) vertices_seen++;
      if (last) begin
         if (vertices_seen < 3) begin
            v.convex  = 1'b0;
            v.too_few = 1'b1;
         end else begin
            fold_turn(tail_x[0], tail_y[0], tail_x[1], tail_y[1], head_x[0], head_y[0]);
            fold_turn(tail_x[1], tail_y[1], head_x[0], head_y[0], head_x[1], head_y[1]);
            v.convex  = !turns_disagree;
            v.too_few = 1'b0;
         end
         outcome_q.push_back(v);
         clear_polygon();
      end
   endfunction

   // receiver side: random stalls, plus a counted hold-off on request
   always @(negedge clock) begin
      if (hold_cycles > 0) begin
         rsp_tready <= 1'b0;
         hold_cycles = hold_cycles - 1;
      end else begin
         rsp_tready <= ($urandom_range(99) >= rsp_stall_pct);
      end
   end

   always @(posedge clock) begin
      verdict_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (outcome_q.size() == 0) begin
            $error("response with no polygon pending: rsp_tdata=%h", rsp_tdata);
            mismatches++;
         end else begin
            want = outcome_q.pop_front();
            if (rsp_tdata[0] !== want.convex) begin
               $error("convex: expected %0d, actual %0d", want.convex, rsp_tdata[0]);
               mismatches++;
            end
            if (rsp_tdata[1] !== want.too_few) begin
               $error("too_few: expected %0d, actual %0d", want.too_few, rsp_tdata[1]);
               mismatches++;
            end
         end
      end
   end

   // called at a falling edge, returns at the falling edge after acceptance
   task automatic send_vertex(logic [VERTEX_BITS-1:0] x, logic [VERTEX_BITS-1:0] y, logic last);
      while ($urandom_range(99) < req_gap_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= (8*REQ_BYTES)'({y, x});
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      fold_vertex(x, y, last);
      @(negedge clock);
   endtask

   task automatic send_shape();
      for (int i = 0; i < shape_x.size(); i++) begin
         send_vertex(16'(shape_x[i]), 16'(shape_y[i]), i == shape_x.size() - 1);
         items_sent++;
      end
   endtask

   function automatic void add_point(int x, int y);
      shape_x.push_back(x);
      shape_y.push_back(y);
   endfunction

   function automatic void clear_shape();
      shape_x.delete();
      shape_y.delete();
   endfunction

   function automatic int cos_milli(int k);
      case (k % 16)
         0:  return 1000;
         1:  return 924;
         2:  return 707;
         3:  return 383;
         4:  return 0;
         5:  return -383;
         6:  return -707;
         7:  return -924;
         8:  return -1000;
         9:  return -924;
         10: return -707;
         11: return -383;
         12: return 0;
         13: return 383;
         14: return 707;
         default: return 924;
      endcase
   endfunction

   // points on a circle at increasing angles, rotated start, either winding
   function automatic void build_convex(int n);
      bit [15:0] used;
      int        picks[16];
      int        count;
      int        r, lim, cx, cy, off, k, j;
      used  = '0;
      count = 0;
      clear_shape();
      while ($countones(used) < n) used[$urandom_range(15)] = 1'b1;
      for (int a = 0; a < 16; a++) begin
         if (used[a]) begin
            picks[count] = a;
            count++;
         end
      end
      r   = $urandom_range(16000, 3);
      lim = 32767 - r;
      cx  = int'($urandom_range(2 * lim)) - lim;
      cy  = int'($urandom_range(2 * lim)) - lim;
      off = $urandom_range(n - 1);
      for (int i = 0; i < n; i++) begin
         j = (off + i) % n;
         k = picks[j];
         add_point(cx + r * cos_milli(k) / 1000, cy + r * cos_milli(k + 12) / 1000);
      end
      if ($urandom_range(1)) begin
         shape_x.reverse();
         shape_y.reverse();
      end
      // sometimes a point on an edge, giving a zero turn
      if ($urandom_range(3) == 0) begin
         j = $urandom_range(n - 2);
         shape_x.insert(j + 1, (shape_x[j] + shape_x[j + 1]) / 2);
         shape_y.insert(j + 1, (shape_y[j] + shape_y[j + 1]) / 2);
      end
   endfunction

   function automatic void build_scatter(int n, bit full_range);
      clear_shape();
      for (int i = 0; i < n; i++) begin
         if (full_range)
            add_point(int'($urandom_range(65535)) - 32768, int'($urandom_range(65535)) - 32768);
         else
            add_point(int'($urandom_range(8)) - 4, int'($urandom_range(8)) - 4);
      end
   endfunction

   function automatic void build_line(int n);
      int bx, by, dx, dy, k;
      clear_shape();
      bx = int'($urandom_range(2000)) - 1000;
      by = int'($urandom_range(2000)) - 1000;
      dx = int'($urandom_range(100)) - 50;
      dy = int'($urandom_range(100)) - 50;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(20);
         add_point(bx + k * dx, by + k * dy);
      end
   endfunction

   task automatic test_directed();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      clear_shape(); add_point(7, -3); send_shape();
      clear_shape(); add_point(-1, 0); add_point(1, 0); send_shape();
      clear_shape();
      add_point(-32768, -32768); add_point(32767, -32768); add_point(32767, 32767);
      send_shape();
      clear_shape();
      add_point(32767, 32767); add_point(32767, -32768); add_point(-32768, 32767);
      send_shape();
      // repeated points only
      clear_shape(); add_point(5, 5); add_point(5, 5); add_point(5, 5); send_shape();
      // dart
      clear_shape();
      add_point(0, 0); add_point(10, 0); add_point(2, 2); add_point(0, 10);
      send_shape();
      // reflex turn only at the first vertex, seen by the last wrap triple
      clear_shape();
      add_point(5, 5); add_point(10, 0); add_point(10, 10); add_point(0, 10); add_point(0, 0);
      send_shape();
   endtask

   task automatic test_random(int unsigned gap_pct, int unsigned stall_pct, int n_items);
      int stop_at;
      int pick;
      req_gap_pct   = gap_pct;
      rsp_stall_pct = stall_pct;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 55)      build_convex($urandom_range(8, 3));
         else if (pick < 70) build_scatter($urandom_range(9, 1), 1'b0);
         else if (pick < 82) build_line($urandom_range(7, 1));
         else                build_scatter($urandom_range(10, 1), 1'b1);
         send_shape();
      end
   endtask

   task automatic test_backpressure();
      req_gap_pct   = 0;
      rsp_stall_pct = 0;
      hold_cycles   = 300;
      repeat (30) begin
         build_convex(3);
         send_shape();
      end
      build_convex(8);
      send_shape();
   endtask

   initial begin
      clear_polygon();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_random(13, 83, 600);
      test_random(83, 13, 600);
      test_random(0, 0, 600);
      test_backpressure();
      req_tvalid <= 1'b0;
      req_tlast  <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatches == 0)
         $display("[polygon_convexity_check] OK");
      else
         $display("[polygon_convexity_check] ERROR");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+design
design/pcc_pkg.sv
design/pcc_front.sv
design/pcc_queue.sv
design/pcc_back.sv
design/polygon_convexity_check.sv
design/pcc_checker.sv
tb/polygon_convexity_check_tb.sv
